FILE: rtl/core/d2q9_pkg.sv
// Shared types, constants and helper functions of the D2Q9 BGK collision pipeline.
package d2q9_pkg;

  // Word format of the distributions.
  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 28;
  localparam int RELAX_BITS = 30;
  localparam int FORCE_BITS = 29;
  localparam int NUM_DIRS   = 9;
  localparam int FIRST_DIAG = 5;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = RELAX_BITS;

  // Internal widths.
  localparam int SUM_BITS  = WORD_BITS + 4;
  localparam int MAG_BITS  = WORD_BITS + 3;
  localparam int RHO_BITS  = WORD_BITS - 1;
  localparam int POLY_BITS = WORD_BITS + 8;
  localparam int WR_BITS   = RHO_BITS - 1;

  // Velocity divider: quotient bits retired per pipeline stage.
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STEPS          = WORD_BITS / DIV_BITS_PER_STAGE;
  localparam int DIV_LAT            = DIV_STEPS + 1;

  // Reciprocal constants for the divisions by nine and by three.
  localparam int M9_SHIFT = 35;
  localparam logic [31:0] M9 = 32'd3817748707;
  localparam int M3_SHIFT = 31;
  localparam logic [29:0] M3 = 30'd715827882;

  localparam logic signed [63:0] WORD_MAX64 = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] WORD_MIN64 = -WORD_MAX64 - 64'sd1;
  localparam logic signed [63:0] ONE64      = 64'sd1 <<< FRAC_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // Lattice vectors in the order of the payload fields.
  localparam int DIR_X [NUM_DIRS] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NUM_DIRS] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RELAX_RATE = 2'd0,
    CFG_FORCE_X    = 2'd1,
    CFG_FORCE_Y    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic  is_wall;
    word_t f_rest;
    word_t f_east;
    word_t f_north;
    word_t f_west;
    word_t f_south;
    word_t f_northeast;
    word_t f_northwest;
    word_t f_southwest;
    word_t f_southeast;
  } cell_in_t;

  typedef struct packed {
    word_t      g_rest;
    word_t      g_east;
    word_t      g_north;
    word_t      g_west;
    word_t      g_south;
    word_t      g_northeast;
    word_t      g_northwest;
    word_t      g_southwest;
    word_t      g_southeast;
    logic [3:0] negative_clamps;
    logic       nonfinite_flag;
  } cell_out_t;

  // Saturate a wide signed value to the word range.
  function automatic word_t sat_word(input logic signed [63:0] v);
    if (v > WORD_MAX64) begin
      return word_t'(WORD_MAX64);
    end else if (v < WORD_MIN64) begin
      return word_t'(WORD_MIN64);
    end
    return word_t'(v);
  endfunction

  // floor(4*r/9) for a remainder of a division by nine.
  function automatic logic [1:0] four_r_div9(input logic [3:0] r);
    logic [1:0] res;
    case (r)
      4'd3, 4'd4: res = 2'd1;
      4'd5, 4'd6: res = 2'd2;
      4'd7, 4'd8: res = 2'd3;
      default:    res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/d2q9_div.sv
// Pipelined restoring divider for (magnitude << FRAC_BITS) / density.
module d2q9_div (
  input  logic                             clk_i,
  input  logic [d2q9_pkg::MAG_BITS-1:0]    mag_i,
  input  logic [d2q9_pkg::RHO_BITS-1:0]    rho_i,
  output logic [d2q9_pkg::WORD_BITS-1:0]   quo_o,
  output logic                             ovf_o
);
  import d2q9_pkg::*;

  localparam int LOW_BITS = WORD_BITS - FRAC_BITS;

  typedef struct packed {
    logic [RHO_BITS-1:0]  rem;
    logic [WORD_BITS-1:0] quo;
    logic [WORD_BITS-1:0] low;
    logic [RHO_BITS-1:0]  den;
    logic                 ovf;
  } div_st_t;

  div_st_t st_q [DIV_LAT];
  div_st_t st_in;
  logic [RHO_BITS-1:0] hi;

  // One stage retires DIV_BITS_PER_STAGE quotient bits.
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t       n;
    logic [RHO_BITS:0] trial;
    n = s;
    for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
      trial = {n.rem, n.low[WORD_BITS-1]};
      n.low = {n.low[WORD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, n.den}) begin
        n.rem = RHO_BITS'(trial - {1'b0, n.den});
        n.quo = {n.quo[WORD_BITS-2:0], 1'b1};
      end else begin
        n.rem = trial[RHO_BITS-1:0];
        n.quo = {n.quo[WORD_BITS-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  // The upper numerator bits form the first remainder; a quotient that
  // cannot fit the word is flagged as overflow.
  always_comb begin
    hi        = mag_i[MAG_BITS-1:LOW_BITS];
    st_in.ovf = (hi >= rho_i);
    st_in.rem = st_in.ovf ? '0 : hi;
    st_in.quo = '0;
    st_in.low = {mag_i[LOW_BITS-1:0], {FRAC_BITS{1'b0}}};
    st_in.den = rho_i;
  end

  // Divider stages.
  always_ff @(posedge clk_i) begin
    st_q[0] <= st_in;
    for (int s = 0; s < DIV_STEPS; s++) begin
      st_q[s+1] <= div_step(st_q[s]);
    end
  end

  assign quo_o = st_q[DIV_STEPS].quo;
  assign ovf_o = st_q[DIV_STEPS].ovf;

endmodule

FILE: rtl/core/d2q9_bgk_collision.sv
// Top level of the D2Q9 BGK collision pipeline for one lattice cell per cycle while busy is low.
//
//   port group        direction  transfer rule
//   start/cell_i      in         taken at an edge with start high and busy low
//   done_o/result_o   out        valid for one cycle while done_o is high
//   cfg_we_i/idx/wdata in        register written at an edge with cfg_we_i high
//
// One cell enters per cycle while busy is low. Its result strobe follows the front
// stages, the velocity divider (two quotient bits per stage over 16 stages) and
// the arithmetic stages after it.
// busy is high only during reset and the cycle after it.
// The receiver cannot stall, so the pipeline advances every cycle.
module d2q9_bgk_collision (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  input  d2q9_pkg::cell_in_t                   cell_i,
  output logic                                 busy,
  output logic                                 done_o,
  output d2q9_pkg::cell_out_t                  result_o,
  input  logic                                 cfg_we_i,
  input  logic [d2q9_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [d2q9_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i
);
  import d2q9_pkg::*;

  localparam int POST_STAGES = 11;
  localparam int AM_BITS     = FORCE_BITS + 1;
  localparam int CP_BITS     = AM_BITS + 30;
  localparam int Q3_BITS     = CP_BITS - M3_SHIFT;
  localparam int P9_BITS     = RHO_BITS + 32;
  localparam int Q9_BITS     = P9_BITS - M9_SHIFT;
  localparam int DIFF_BITS   = WORD_BITS + 1;

  typedef struct packed {
    logic                wall;
    logic                nonpos;
    logic                neg_x;
    logic                neg_y;
    logic [RHO_BITS-1:0] rho;
  } side_t;

  // Configuration registers.
  logic [RELAX_BITS-1:0]        relax_q;
  logic signed [FORCE_BITS-1:0] fx_q, fy_q;
  logic                         busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= RELAX_BITS'(1) << FRAC_BITS;
      fx_q    <= '0;
      fy_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RELAX_RATE: relax_q <= cfg_wdata_i[RELAX_BITS-1:0];
        CFG_FORCE_X:    fx_q    <= cfg_wdata_i[FORCE_BITS-1:0];
        CFG_FORCE_Y:    fy_q    <= cfg_wdata_i[FORCE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Busy only while coming out of reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end
  assign busy = busy_q;

  logic accept;
  assign accept = start && !busy;

  // Forcing term per direction, derived from the force registers over four stages;
  // the user must change the registers only while no cell is in flight (not enforced).
  logic [AM_BITS-1:0] am_c1_q [4], am_c2_q [4];
  logic               sg_c1_q [4], sg_c2_q [4], sg_c3_q [4];
  logic [CP_BITS-1:0] cp_c2_q [4];
  logic [Q3_BITS-1:0] q3_c3_q [4];
  word_t              frc_q   [NUM_DIRS];

  logic signed [AM_BITS-1:0] fs_c [4];
  logic [Q3_BITS-1:0]        q0_c [4];
  logic [AM_BITS-1:0]        r3_c [4];
  word_t                     fb_c [4];

  always_comb begin
    fs_c[0] = AM_BITS'(fx_q);
    fs_c[1] = AM_BITS'(fy_q);
    fs_c[2] = AM_BITS'(fx_q) + AM_BITS'(fy_q);
    fs_c[3] = AM_BITS'(fx_q) - AM_BITS'(fy_q);
    for (int i = 0; i < 4; i++) begin
      q0_c[i] = cp_c2_q[i][CP_BITS-1:M3_SHIFT];
      r3_c[i] = am_c2_q[i] - AM_BITS'({q0_c[i], 1'b0}) - AM_BITS'(q0_c[i]);
    end
    for (int i = 0; i < 4; i++) begin
      if (i < 2) begin
        fb_c[i] = word_t'(q3_c3_q[i]);
      end else begin
        fb_c[i] = word_t'(q3_c3_q[i] >> 2);
      end
      if (sg_c3_q[i]) begin
        fb_c[i] = -fb_c[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      sg_c1_q[i] <= fs_c[i][AM_BITS-1];
      am_c1_q[i] <= fs_c[i][AM_BITS-1] ? AM_BITS'(-fs_c[i]) : AM_BITS'(fs_c[i]);
      sg_c2_q[i] <= sg_c1_q[i];
      am_c2_q[i] <= am_c1_q[i];
      cp_c2_q[i] <= CP_BITS'(am_c1_q[i]) * CP_BITS'(M3);
      sg_c3_q[i] <= sg_c2_q[i];
      q3_c3_q[i] <= q0_c[i] + Q3_BITS'(r3_c[i] >= AM_BITS'(3));
    end
    frc_q[0] <= '0;
    frc_q[1] <= fb_c[0];
    frc_q[2] <= fb_c[1];
    frc_q[3] <= -fb_c[0];
    frc_q[4] <= -fb_c[1];
    frc_q[5] <= fb_c[2];
    frc_q[6] <= -fb_c[3];
    frc_q[7] <= -fb_c[2];
    frc_q[8] <= fb_c[3];
  end

  // Front stages: input register, partial sums, moments, magnitudes.
  logic v1_q, v2_q, v3_q, v4_q;
  logic wall1_q, wall2_q, wall3_q, wall4_q;
  word_t f1_q [NUM_DIRS], f2_q [NUM_DIRS], f3_q [NUM_DIRS], f4_q [NUM_DIRS];
  logic signed [SUM_BITS-1:0] rho_a_q, rho_b_q, mx_a_q, mx_b_q, my_a_q, my_b_q;
  logic signed [SUM_BITS-1:0] rho3_q, mx3_q, my3_q;
  logic                       nonpos4_q, negx4_q, negy4_q;
  logic [RHO_BITS-1:0]        rho4_q;
  logic [MAG_BITS-1:0]        magx4_q, magy4_q;
  word_t                      f_in [NUM_DIRS];
  logic signed [SUM_BITS-1:0] e [NUM_DIRS];

  always_comb begin
    f_in[0] = cell_i.f_rest;
    f_in[1] = cell_i.f_east;
    f_in[2] = cell_i.f_north;
    f_in[3] = cell_i.f_west;
    f_in[4] = cell_i.f_south;
    f_in[5] = cell_i.f_northeast;
    f_in[6] = cell_i.f_northwest;
    f_in[7] = cell_i.f_southwest;
    f_in[8] = cell_i.f_southeast;
    for (int k = 0; k < NUM_DIRS; k++) begin
      e[k] = SUM_BITS'(f1_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wall1_q <= cell_i.is_wall;
    f1_q    <= f_in;
    wall2_q <= wall1_q;
    f2_q    <= f1_q;
    rho_a_q <= e[0] + e[1] + e[2] + e[3] + e[4];
    rho_b_q <= e[5] + e[6] + e[7] + e[8];
    mx_a_q  <= e[1] - e[3];
    mx_b_q  <= e[5] - e[6] - e[7] + e[8];
    my_a_q  <= e[2] - e[4];
    my_b_q  <= e[5] + e[6] - e[7] - e[8];
    wall3_q <= wall2_q;
    f3_q    <= f2_q;
    rho3_q  <= rho_a_q + rho_b_q;
    mx3_q   <= mx_a_q + mx_b_q;
    my3_q   <= my_a_q + my_b_q;
    wall4_q   <= wall3_q;
    f4_q      <= f3_q;
    nonpos4_q <= (rho3_q <= 0);
    rho4_q    <= (64'(rho3_q) > WORD_MAX64) ? {RHO_BITS{1'b1}} : rho3_q[RHO_BITS-1:0];
    negx4_q   <= mx3_q[SUM_BITS-1];
    negy4_q   <= my3_q[SUM_BITS-1];
    magx4_q   <= mx3_q[SUM_BITS-1] ? MAG_BITS'(-mx3_q) : MAG_BITS'(mx3_q);
    magy4_q   <= my3_q[SUM_BITS-1] ? MAG_BITS'(-my3_q) : MAG_BITS'(my3_q);
  end

  // Velocity dividers and the matching delay line for the rest of the cell.
  logic [WORD_BITS-1:0] quox, quoy;
  logic                 ovfx, ovfy;

  d2q9_div u_div_x (
    .clk_i (clk_i),
    .mag_i (magx4_q),
    .rho_i (rho4_q),
    .quo_o (quox),
    .ovf_o (ovfx)
  );

  d2q9_div u_div_y (
    .clk_i (clk_i),
    .mag_i (magy4_q),
    .rho_i (rho4_q),
    .quo_o (quoy),
    .ovf_o (ovfy)
  );

  logic  dl_v_q [DIV_LAT];
  side_t dl_q   [DIV_LAT];
  word_t dl_f_q [DIV_LAT][NUM_DIRS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dl_v_q[i] <= 1'b0;
      end
    end else begin
      dl_v_q[0] <= v4_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_v_q[i] <= dl_v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q[0]   <= '{wall: wall4_q, nonpos: nonpos4_q, neg_x: negx4_q, neg_y: negy4_q,
                   rho: rho4_q};
    dl_f_q[0] <= f4_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      dl_q[i]   <= dl_q[i-1];
      dl_f_q[i] <= dl_f_q[i-1];
    end
  end

  // Saturate a quotient magnitude into a signed velocity.
  function automatic word_t mk_vel(input logic [WORD_BITS-1:0] q, input logic ovf,
                                   input logic neg);
    logic big;
    big = ovf || q[WORD_BITS-1];
    if (big) begin
      return neg ? word_t'(WORD_MIN64) : word_t'(WORD_MAX64);
    end
    return neg ? -word_t'(q) : word_t'(q);
  endfunction

  // Back stages: valid bits.
  logic [POST_STAGES-1:0] pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      pv_q <= {pv_q[POST_STAGES-2:0], dl_v_q[DIV_LAT-1]};
    end
  end

  // Back stages: payload.
  side_t s5_q, s6_q, s7_q, s8_q, s9_q, s10_q, s11_q, s12_q, s13_q, s14_q;
  word_t f5_q [NUM_DIRS], f6_q [NUM_DIRS], f7_q [NUM_DIRS], f8_q [NUM_DIRS];
  word_t f9_q [NUM_DIRS], f10_q [NUM_DIRS], f11_q [NUM_DIRS], f12_q [NUM_DIRS];
  word_t f13_q [NUM_DIRS], f14_q [NUM_DIRS];
  word_t ux5_q, uy5_q, ux6_q, uy6_q;
  logic [P9_BITS-1:0] p9_5_q;
  word_t cu6_q [NUM_DIRS], cu7_q [NUM_DIRS];
  logic [Q9_BITS-1:0] q9_6_q;
  logic [3:0] r9_6_q;
  logic signed [63:0] sq7_q [NUM_DIRS];
  logic signed [63:0] uxx7_q, uyy7_q;
  logic [WR_BITS-1:0] wr7_q [NUM_DIRS], wr8_q [NUM_DIRS], wr9_q [NUM_DIRS];
  logic signed [POLY_BITS-1:0] cu3_8_q [NUM_DIRS], c9h_8_q [NUM_DIRS], u3h_8_q;
  word_t poly9_q [NUM_DIRS];
  logic signed [63:0] wp10_q [NUM_DIRS];
  word_t feq11_q [NUM_DIRS], feq12_q [NUM_DIRS], feq13_q [NUM_DIRS], feq14_q [NUM_DIRS];
  logic signed [DIFF_BITS-1:0] diff12_q [NUM_DIRS];
  logic signed [63:0] pr13_q [NUM_DIRS];
  logic signed [POLY_BITS-1:0] o14_q [NUM_DIRS];
  logic neg14_q [NUM_DIRS];

  logic signed [63:0] cu_c [NUM_DIRS];
  logic [Q9_BITS-1:0] q0_9;
  logic [WORD_BITS-1:0] r0_9;
  logic [POLY_BITS-1:0] cu2_c [NUM_DIRS];
  logic [POLY_BITS-1:0] uu_c;

  always_comb begin
    // Lattice projections of the velocity.
    for (int k = 0; k < NUM_DIRS; k++) begin
      cu_c[k] = '0;
      if (DIR_X[k] > 0) begin
        cu_c[k] = cu_c[k] + 64'(ux5_q);
      end else if (DIR_X[k] < 0) begin
        cu_c[k] = cu_c[k] - 64'(ux5_q);
      end
      if (DIR_Y[k] > 0) begin
        cu_c[k] = cu_c[k] + 64'(uy5_q);
      end else if (DIR_Y[k] < 0) begin
        cu_c[k] = cu_c[k] - 64'(uy5_q);
      end
    end
    // Density divided by nine, estimate and remainder.
    q0_9 = p9_5_q[P9_BITS-1:M9_SHIFT];
    r0_9 = WORD_BITS'(s5_q.rho) - WORD_BITS'({q0_9, 3'b000}) - WORD_BITS'(q0_9);
    // Squared terms rescaled to the fraction.
    for (int k = 0; k < NUM_DIRS; k++) begin
      cu2_c[k] = POLY_BITS'(sq7_q[k] >>> FRAC_BITS);
    end
    uu_c = POLY_BITS'(uxx7_q >>> FRAC_BITS) + POLY_BITS'(uyy7_q >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    // Velocity and the density reciprocal product.
    s5_q   <= dl_q[DIV_LAT-1];
    f5_q   <= dl_f_q[DIV_LAT-1];
    ux5_q  <= mk_vel(quox, ovfx, dl_q[DIV_LAT-1].neg_x);
    uy5_q  <= mk_vel(quoy, ovfy, dl_q[DIV_LAT-1].neg_y);
    p9_5_q <= P9_BITS'(dl_q[DIV_LAT-1].rho) * P9_BITS'(M9);

    // Projections and the corrected quotient by nine.
    s6_q  <= s5_q;
    f6_q  <= f5_q;
    ux6_q <= ux5_q;
    uy6_q <= uy5_q;
    for (int k = 0; k < NUM_DIRS; k++) begin
      cu6_q[k] <= sat_word(cu_c[k]);
    end
    if (r0_9 >= WORD_BITS'(9)) begin
      q9_6_q <= q0_9 + Q9_BITS'(1);
      r9_6_q <= 4'(r0_9 - WORD_BITS'(9));
    end else begin
      q9_6_q <= q0_9;
      r9_6_q <= r0_9[3:0];
    end

    // Squares and the weighted densities.
    s7_q   <= s6_q;
    f7_q   <= f6_q;
    cu7_q  <= cu6_q;
    uxx7_q <= ux6_q * ux6_q;
    uyy7_q <= uy6_q * uy6_q;
    for (int k = 0; k < NUM_DIRS; k++) begin
      sq7_q[k] <= cu6_q[k] * cu6_q[k];
      if (k == 0) begin
        wr7_q[k] <= WR_BITS'({q9_6_q, 2'b00}) + WR_BITS'(four_r_div9(r9_6_q));
      end else if (k < FIRST_DIAG) begin
        wr7_q[k] <= WR_BITS'(q9_6_q);
      end else begin
        wr7_q[k] <= WR_BITS'(q9_6_q >> 2);
      end
    end

    // Polynomial terms: 3cu, 4.5cu^2 and 1.5u.u.
    s8_q    <= s7_q;
    f8_q    <= f7_q;
    wr8_q   <= wr7_q;
    u3h_8_q <= POLY_BITS'(((uu_c << 1) + uu_c) >> 1);
    for (int k = 0; k < NUM_DIRS; k++) begin
      cu3_8_q[k] <= POLY_BITS'(cu7_q[k]) + POLY_BITS'(cu7_q[k]) + POLY_BITS'(cu7_q[k]);
      c9h_8_q[k] <= POLY_BITS'(((cu2_c[k] << 3) + cu2_c[k]) >> 1);
    end

    // Bracketed polynomial.
    s9_q  <= s8_q;
    f9_q  <= f8_q;
    wr9_q <= wr8_q;
    for (int k = 0; k < NUM_DIRS; k++) begin
      poly9_q[k] <= sat_word(ONE64 + 64'(cu3_8_q[k]) + 64'(c9h_8_q[k]) - 64'(u3h_8_q));
    end

    // Weighted density times polynomial.
    s10_q <= s9_q;
    f10_q <= f9_q;
    for (int k = 0; k < NUM_DIRS; k++) begin
      wp10_q[k] <= $signed({1'b0, wr9_q[k]}) * poly9_q[k];
    end

    // Equilibrium.
    s11_q <= s10_q;
    f11_q <= f10_q;
    for (int k = 0; k < NUM_DIRS; k++) begin
      feq11_q[k] <= sat_word(wp10_q[k] >>> FRAC_BITS);
    end

    // Distance from equilibrium.
    s12_q   <= s11_q;
    f12_q   <= f11_q;
    feq12_q <= feq11_q;
    for (int k = 0; k < NUM_DIRS; k++) begin
      diff12_q[k] <= DIFF_BITS'(f11_q[k]) - DIFF_BITS'(feq11_q[k]);
    end

    // Relaxation product.
    s13_q   <= s12_q;
    f13_q   <= f12_q;
    feq13_q <= feq12_q;
    for (int k = 0; k < NUM_DIRS; k++) begin
      pr13_q[k] <= diff12_q[k] * $signed({1'b0, relax_q});
    end

    // Relaxed value plus forcing, and its sign.
    s14_q   <= s13_q;
    f14_q   <= f13_q;
    feq14_q <= feq13_q;
    for (int k = 0; k < NUM_DIRS; k++) begin
      o14_q[k]   <= POLY_BITS'(64'(f13_q[k]) - (pr13_q[k] >>> FRAC_BITS) + 64'(frc_q[k]));
      neg14_q[k] <= (64'(f13_q[k]) - (pr13_q[k] >>> FRAC_BITS) + 64'(frc_q[k])) < 0;
    end
  end

  // Output stage: wall bypass, density guard, negative replacement.
  word_t      g_d [NUM_DIRS];
  word_t      g_q [NUM_DIRS];
  logic [3:0] clamps_d, clamps_q;
  logic       flag_q, wall15_q;

  always_comb begin
    clamps_d = '0;
    for (int k = 0; k < NUM_DIRS; k++) begin
      if (s14_q.wall) begin
        g_d[k] = f14_q[k];
      end else if (s14_q.nonpos) begin
        g_d[k] = '0;
      end else if (neg14_q[k]) begin
        g_d[k]   = feq14_q[k];
        clamps_d = clamps_d + 4'd1;
      end else begin
        g_d[k] = sat_word(64'(o14_q[k]));
      end
    end
    if (s14_q.wall || s14_q.nonpos) begin
      clamps_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q      <= g_d;
    clamps_q <= clamps_d;
    flag_q   <= !s14_q.wall && s14_q.nonpos;
    wall15_q <= s14_q.wall;
  end

  assign done_o = pv_q[POST_STAGES-1];

  always_comb begin
    result_o.g_rest          = g_q[0];
    result_o.g_east          = g_q[1];
    result_o.g_north         = g_q[2];
    result_o.g_west          = g_q[3];
    result_o.g_south         = g_q[4];
    result_o.g_northeast     = g_q[5];
    result_o.g_northwest     = g_q[6];
    result_o.g_southwest     = g_q[7];
    result_o.g_southeast     = g_q[8];
    result_o.negative_clamps = clamps_q;
    result_o.nonfinite_flag  = flag_q;
  end

  // A zeroed cell reports no clamps and zero distributions.
  a_nonfinite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.nonfinite_flag |-> result_o.negative_clamps == 4'd0 &&
    result_o.g_rest == '0 && result_o.g_east == '0 && result_o.g_southeast == '0)
    else $error("nonfinite result with nonzero payload");

  // No more clamps than directions.
  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.negative_clamps <= 4'd9)
    else $error("clamp count out of range");

  // A wall cell never reports clamps or a density fault.
  a_wall_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && wall15_q |-> !result_o.nonfinite_flag && result_o.negative_clamps == 4'd0)
    else $error("wall cell reported collision status");

endmodule
